>>> hw/rtl/sha1md_pkg.sv
// SHA-1 digest engine: shared types, constants and helper functions.
// Used by sha1md_round and sha1_message_digest_top; depends on nothing.
package sha1md_pkg;

	localparam int unsigned CHAIN_WORDS = 5;
	localparam int unsigned BLOCK_WORDS = 16;
	localparam int unsigned ROUNDS      = 80;

	localparam logic [0:CHAIN_WORDS-1][31:0] H_INIT = {
		32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
	};

	localparam logic [31:0] K_00_19 = 32'h5A827999;
	localparam logic [31:0] K_20_39 = 32'h6ED9EBA1;
	localparam logic [31:0] K_40_59 = 32'h8F1BBCDC;
	localparam logic [31:0] K_60_79 = 32'hCA62C1D6;

	localparam logic [7:0]  PAD_BYTE = 8'h80;
	localparam logic [31:0] PAD_WORD = {PAD_BYTE, 24'h0};
	localparam logic [2:0]  FULL_BYTES = 3'd4;
	localparam logic [2:0]  LAST_INDEX = 3'd4;

	// Working variables of the compression.
	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} work_t;

	// Keep the leading bytes; a partial last word gets the 0x80 marker after them.
	function automatic logic [31:0] pad_last(input logic [31:0] word, input logic [2:0] cnt);
		logic [31:0] r;
		case (cnt)
			3'd0:    r = PAD_WORD;
			3'd1:    r = {word[31:24], PAD_BYTE, 16'h0};
			3'd2:    r = {word[31:16], PAD_BYTE, 8'h0};
			3'd3:    r = {word[31:8], PAD_BYTE};
			default: r = word;
		endcase
		return r;
	endfunction

endpackage

>>> hw/rtl/sha1md_round.sv
// SHA-1 round function: one of the 80 compression rounds.
// Depends on sha1md_pkg (work_t and round constants).
module sha1md_round (
	input  logic [6:0]         rnd,
	input  logic [31:0]        w,
	input  sha1md_pkg::work_t  cur,
	output sha1md_pkg::work_t  nxt
);

	logic [31:0] f;
	logic [31:0] k;

	always_comb begin
		if (rnd < 7'd20) begin
			f = (cur.b & cur.c) | (~cur.b & cur.d);
			k = sha1md_pkg::K_00_19;
		end else if (rnd < 7'd40) begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1md_pkg::K_20_39;
		end else if (rnd < 7'd60) begin
			f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
			k = sha1md_pkg::K_40_59;
		end else begin
			f = cur.b ^ cur.c ^ cur.d;
			k = sha1md_pkg::K_60_79;
		end
	end

	always_comb begin
		nxt.a = {cur.a[26:0], cur.a[31:27]} + f + cur.e + k + w;
		nxt.b = cur.a;
		nxt.c = {cur.b[1:0], cur.b[31:2]};
		nxt.d = cur.c;
		nxt.e = cur.d;
	end

endmodule

>>> hw/rtl/sha1_message_digest_top.sv
// SHA-1 message digest engine, top level.
// Depends on sha1md_pkg and sha1md_round.
//
// Channel   Direction  Handshake           Payload
// input     in         in_valid/in_stall   message_word, byte_count, final_item
// output    out        out_valid/out_stall digest_word, digest_index, digest_done
//
// Flow: a message word is taken while the block is idle. Every 16th word
// starts a compression (one load, 80 rounds on the single round unit, one
// chaining add), and no new word is taken until it is done.
// The final word adds the padding words, written one at a time, one or two
// more compressions, and five digest transactions.
// Reset: arst_n clears control, loads the initial chaining words and sets the
// bit count and fill position to zero; the block buffer memory is not cleared.
// Stalls: in_stall is high whenever the block is not idle; out_stall holds
// the current digest word until it is taken.
module sha1_message_digest_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] message_word,
	input  logic [2:0]  byte_count,
	input  logic        final_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] digest_word,
	output logic [2:0]  digest_index,
	output logic        digest_done
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PAD,
		ST_LOAD,
		ST_COMP,
		ST_FIN,
		ST_OUT
	} state_t;

	state_t            state_q;
	logic [3:0]        fill_q;
	logic [63:0]       bits_q;
	logic              padding_q;
	logic              need80_q;
	logic              len_hi_q;
	logic [6:0]        rnd_q;
	logic [2:0]        out_idx_q;
	logic [31:0]       chain_q [sha1md_pkg::CHAIN_WORDS];
	sha1md_pkg::work_t work_q;
	sha1md_pkg::work_t work_nxt;
	sha1md_pkg::work_t chain_work;
	logic [31:0]       sched_q [sha1md_pkg::BLOCK_WORDS];

	// Block buffer: 16 x 32 memory, one write port, one registered read port.
	logic [31:0]       buf_mem [sha1md_pkg::BLOCK_WORDS];
	logic [31:0]       rdata_q;
	logic              mem_we;
	logic [31:0]       mem_wdata;
	logic [3:0]        mem_raddr;

	logic              in_take;
	logic [2:0]        cnt_sat;
	logic [31:0]       pad_data;
	logic [31:0]       w_cur;
	logic [31:0]       w_sched;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = (state_q == ST_OUT);

	assign digest_word  = chain_q[out_idx_q];
	assign digest_index = out_idx_q;
	assign digest_done  = (out_idx_q == sha1md_pkg::LAST_INDEX);

	// Saturate the byte count of the last word at four.
	assign cnt_sat = (byte_count > sha1md_pkg::FULL_BYTES) ? sha1md_pkg::FULL_BYTES
		: byte_count;

	// Padding words: marker first if still owed, then zeros, then the length
	// in the last two slots of the block.
	always_comb begin
		if (need80_q) begin
			pad_data = sha1md_pkg::PAD_WORD;
		end else if (fill_q == 4'd14) begin
			pad_data = bits_q[63:32];
		end else if (fill_q == 4'd15 && len_hi_q) begin
			pad_data = bits_q[31:0];
		end else begin
			pad_data = 32'h0;
		end
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = pad_data;
		if (in_take) begin
			mem_we    = 1'b1;
			mem_wdata = final_item ? sha1md_pkg::pad_last(message_word, cnt_sat)
				: message_word;
		end else if (state_q == ST_PAD) begin
			mem_we = 1'b1;
		end
	end

	// Read word 0 during load, then one word ahead of the round counter.
	// Every write of a block lands before its load starts, so reads never race
	// a write to the same entry.
	assign mem_raddr = (state_q == ST_COMP) ? (rnd_q[3:0] + 4'd1) : 4'd0;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			buf_mem[fill_q] <= mem_wdata;
		end
		rdata_q <= buf_mem[mem_raddr];
	end

	// Message schedule: first 16 words from memory, the rest from the taps.
	assign w_sched = {sched_q[13][30:0] ^ sched_q[8][30:0] ^ sched_q[2][30:0]
		^ sched_q[0][30:0], sched_q[13][31] ^ sched_q[8][31] ^ sched_q[2][31]
		^ sched_q[0][31]};
	assign w_cur = (rnd_q < 7'd16) ? rdata_q : w_sched;

	always_ff @(posedge clk) begin
		if (state_q == ST_COMP) begin
			for (int i = 0; i < 15; i++) begin
				sched_q[i] <= sched_q[i+1];
			end
			sched_q[15] <= w_cur;
		end
	end

	sha1md_round u_round (
		.rnd (rnd_q),
		.w   (w_cur),
		.cur (work_q),
		.nxt (work_nxt)
	);

	assign chain_work = '{a: chain_q[0], b: chain_q[1], c: chain_q[2],
		d: chain_q[3], e: chain_q[4]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			fill_q    <= 4'd0;
			bits_q    <= 64'd0;
			padding_q <= 1'b0;
			need80_q  <= 1'b0;
			len_hi_q  <= 1'b0;
			rnd_q     <= 7'd0;
			out_idx_q <= 3'd0;
			work_q    <= '0;
			for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
				chain_q[i] <= sha1md_pkg::H_INIT[i];
			end
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						fill_q <= fill_q + 4'd1;
						if (final_item) begin
							bits_q    <= bits_q + {58'd0, cnt_sat, 3'b000};
							padding_q <= 1'b1;
							need80_q  <= (cnt_sat == sha1md_pkg::FULL_BYTES);
						end else begin
							bits_q <= bits_q + 64'd32;
						end
						if (fill_q == 4'd15) begin
							state_q <= ST_LOAD;
						end else if (final_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					fill_q   <= fill_q + 4'd1;
					need80_q <= 1'b0;
					if (!need80_q && fill_q == 4'd14) begin
						len_hi_q <= 1'b1;
					end
					if (fill_q == 4'd15) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					work_q  <= chain_work;
					rnd_q   <= 7'd0;
					state_q <= ST_COMP;
				end
				ST_COMP: begin
					work_q <= work_nxt;
					rnd_q  <= rnd_q + 7'd1;
					if (rnd_q == 7'(sha1md_pkg::ROUNDS - 1)) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					chain_q[0] <= chain_q[0] + work_q.a;
					chain_q[1] <= chain_q[1] + work_q.b;
					chain_q[2] <= chain_q[2] + work_q.c;
					chain_q[3] <= chain_q[3] + work_q.d;
					chain_q[4] <= chain_q[4] + work_q.e;
					out_idx_q  <= 3'd0;
					if (!padding_q) begin
						state_q <= ST_IDLE;
					end else if (len_hi_q) begin
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_PAD;
					end
				end
				ST_OUT: begin
					if (!out_stall) begin
						if (out_idx_q == sha1md_pkg::LAST_INDEX) begin
							// Last digest word taken: back to the initial state.
							state_q   <= ST_IDLE;
							fill_q    <= 4'd0;
							bits_q    <= 64'd0;
							padding_q <= 1'b0;
							need80_q  <= 1'b0;
							len_hi_q  <= 1'b0;
							out_idx_q <= 3'd0;
							for (int i = 0; i < sha1md_pkg::CHAIN_WORDS; i++) begin
								chain_q[i] <= sha1md_pkg::H_INIT[i];
							end
						end else begin
							out_idx_q <= out_idx_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

>>> hw/rtl/sha1md_checker.sv
// Port-level checker for the SHA-1 digest engine, bound to the top level.
// Depends only on the top level's port list.
module sha1md_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] digest_word,
	input logic [2:0]  digest_index,
	input logic        digest_done
);

	// Hold a stalled digest transaction.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(digest_word)
			&& $stable(digest_index))
		else $error("stalled digest transaction changed");

	// Flag completion only on the last word.
	a_done_idx: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (digest_done == (digest_index == 3'd4)))
		else $error("digest_done out of step with digest_index");

	// Advance the index by one after each taken word until done.
	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !digest_done
			|=> out_valid && digest_index == $past(digest_index) + 3'd1)
		else $error("digest words not emitted in order");

	// Drop output valid once the last word is taken.
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && digest_done |=> !out_valid)
		else $error("extra digest word after the last");

	// Hold off input while the digest is being delivered.
	a_no_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input open during digest output");

endmodule

bind sha1_message_digest_top sha1md_checker u_sha1md_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.digest_word  (digest_word),
	.digest_index (digest_index),
	.digest_done  (digest_done)
);
